// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the tilt block.
// Depends on nothing; each macro takes its clock and active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on every rising edge of clk, off while rst_n is low.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Assert that a condition is never true.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    `ASSERT_PROP(lbl, clk, rst_n, !(cond), msg)

`endif

// ===== rtl/tac_pkg.sv =====
// Package of the tilt block: datapath widths, arctangent table and status type.
// Used by tac_cordic and tilt_from_accel_and_gyro_integrator; depends on nothing.
package tac_pkg;

    localparam int XW        = 36;
    localparam int ZW        = 28;
    localparam int ITER_W    = 5;
    localparam int ATAN_LEN  = 24;
    localparam int GAIN_W    = 24;
    localparam int ACC_W     = 48;
    localparam int PROD_W    = 41;

    localparam logic signed [ZW-1:0] PI_Q24      = 28'sd52707179;
    localparam logic signed [ZW-1:0] ROUND_HALF  = 28'sd1024;
    localparam logic signed [ZW-1:0] ANGLE_LIMIT = 28'sd25736;
    localparam logic [GAIN_W-1:0]    GAIN_RESET  = 24'd14642;

    localparam logic [23:0] ATAN_Q24 [ATAN_LEN] = '{
        24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331,
        24'd1047214,  24'd524117,  24'd262123,  24'd131069,
        24'd65536,    24'd32768,   24'd16384,   24'd8192,
        24'd4096,     24'd2048,    24'd1024,    24'd512,
        24'd256,      24'd128,     24'd64,      24'd32,
        24'd16,       24'd8,       24'd4,       24'd2
    };

    typedef struct packed {
        logic busy;
        logic done;
    } t_cordic_stat;

endpackage

// ===== rtl/tac_cordic.sv =====
// Iterative CORDIC vectoring unit: -atan2(z, y) in 2^-13 rad, one rotation a cycle.
// Depends on tac_pkg.
module tac_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [15:0]    i_ay,
    input  logic signed [15:0]    i_az,
    output tac_pkg::t_cordic_stat o_stat,
    output logic signed [15:0]    o_angle
);

    localparam int NSTEP = (CORDIC_STEPS > tac_pkg::ATAN_LEN) ? tac_pkg::ATAN_LEN
                                                               : CORDIC_STEPS;
    localparam logic [tac_pkg::ITER_W-1:0] LAST = tac_pkg::ITER_W'(NSTEP - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ITER  = 2'd1;
    localparam logic [1:0] S_ROUND = 2'd2;

    logic [1:0]                      r_state;
    logic                            r_done;
    logic                            r_zero;
    logic [tac_pkg::ITER_W-1:0]      r_iter;
    logic signed [tac_pkg::XW-1:0]   r_x, r_y;
    logic signed [tac_pkg::ZW-1:0]   r_z;
    logic signed [15:0]              r_angle;

    logic signed [tac_pkg::XW-1:0]   x0, y0, dx, dy, n_x, n_y;
    logic signed [tac_pkg::ZW-1:0]   z0, step_ang, n_z, rnd, lim, n_angle_w;
    logic                            y_pos;

    always_comb begin
        x0 = {{4{i_ay[15]}}, i_ay, 16'b0};
        y0 = {{4{i_az[15]}}, i_az, 16'b0};
        z0 = '0;
        if (i_ay[15]) begin
            x0 = -x0;
            y0 = -y0;
            z0 = i_az[15] ? -tac_pkg::PI_Q24 : tac_pkg::PI_Q24;
        end
    end

    always_comb begin
        dx       = r_y >>> r_iter;
        dy       = r_x >>> r_iter;
        step_ang = $signed({4'b0, tac_pkg::ATAN_Q24[r_iter]});
        y_pos    = !r_y[tac_pkg::XW-1] && (r_y != '0);
        if (y_pos) begin
            n_x = r_x + dx;
            n_y = r_y - dy;
            n_z = r_z + step_ang;
        end else begin
            n_x = r_x - dx;
            n_y = r_y + dy;
            n_z = r_z - step_ang;
        end
    end

    always_comb begin
        rnd = (r_z + tac_pkg::ROUND_HALF) >>> 11;
        lim = rnd;
        if (rnd > tac_pkg::ANGLE_LIMIT) begin
            lim = tac_pkg::ANGLE_LIMIT;
        end else if (rnd < -tac_pkg::ANGLE_LIMIT) begin
            lim = -tac_pkg::ANGLE_LIMIT;
        end
        n_angle_w = r_zero ? '0 : -lim;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == S_ROUND);
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_ITER;
                    end
                end
                S_ITER: begin
                    if (r_iter == LAST) begin
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_x    <= x0;
            r_y    <= y0;
            r_z    <= z0;
            r_zero <= (i_ay == '0) && (i_az == '0);
            r_iter <= '0;
        end else if (r_state == S_ITER) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_iter <= r_iter + 1'b1;
        end
        if (r_state == S_ROUND) begin
            r_angle <= n_angle_w[15:0];
        end
    end

    assign o_stat.busy = (r_state != S_IDLE);
    assign o_stat.done = r_done;
    assign o_angle     = r_angle;

endmodule

// ===== rtl/tilt_from_accel_and_gyro_integrator.sv =====
// Top level: IMU tilt by CORDIC plus an integrated, seeded gyro angle.
// Depends on tac_pkg, tac_cordic and assert_macros.svh.
//
//  channel | direction | handshake                  | fields
//  input   | in        | i_in_valid / o_in_stall    | i_accel_y, i_accel_z, i_gyro_rate
//  output  | out       | o_out_valid / i_out_stall  | o_accel_angle, o_gyro_tilt
//  config  | in        | i_cfg_we                   | i_cfg_data (rate_gain)
//
// Each word passes the accept step, the micro-rotations in the shared shift-add stage of
// tac_cordic, a rounding step, the registered done flag and one accumulator update step.
// Reset clears the sequencer, the seed flag and the accumulator and loads the default gain.
// The result sits in an output register; the update cycle holds while an
// earlier word there is stalled, and no new word is taken until it is done.
`include "assert_macros.svh"

module tilt_from_accel_and_gyro_integrator #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [15:0]                 i_accel_y,
    input  logic signed [15:0]                 i_accel_z,
    input  logic signed [15:0]                 i_gyro_rate,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [15:0]                 o_accel_angle,
    output logic signed [31:0]                 o_gyro_tilt,
    input  logic                               i_cfg_we,
    input  logic [tac_pkg::GAIN_W-1:0]         i_cfg_data
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WAIT  = 2'd1;
    localparam logic [1:0] S_FINAL = 2'd2;

    logic [1:0]                        r_state;
    logic                              r_seeded;
    logic signed [tac_pkg::ACC_W-1:0]  r_acc;
    logic [tac_pkg::GAIN_W-1:0]        r_gain;
    logic signed [tac_pkg::PROD_W-1:0] r_prod;
    logic                              r_out_valid;
    logic signed [15:0]                r_accel_angle;
    logic signed [31:0]                r_gyro_tilt;

    logic                              accept, fin;
    tac_pkg::t_cordic_stat             cstat;
    logic signed [15:0]                tilt;
    logic signed [tac_pkg::ACC_W:0]    sum;
    logic signed [tac_pkg::ACC_W-1:0]  n_acc;

    assign accept = i_in_valid && !o_in_stall;
    assign fin    = (r_state == S_FINAL) && (!r_out_valid || !i_out_stall);

    tac_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_ay    (i_accel_y),
        .i_az    (i_accel_z),
        .o_stat  (cstat),
        .o_angle (tilt)
    );

    always_comb begin
        sum = {r_acc[tac_pkg::ACC_W-1], r_acc}
            + {{(tac_pkg::ACC_W + 1 - tac_pkg::PROD_W){r_prod[tac_pkg::PROD_W-1]}}, r_prod};
        if (!r_seeded) begin
            n_acc = {{13{tilt[15]}}, tilt, 19'b0};
        end else if (sum[tac_pkg::ACC_W] != sum[tac_pkg::ACC_W-1]) begin
            n_acc = {sum[tac_pkg::ACC_W], {(tac_pkg::ACC_W - 1){!sum[tac_pkg::ACC_W]}}};
        end else begin
            n_acc = sum[tac_pkg::ACC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seeded    <= 1'b0;
            r_acc       <= '0;
            r_gain      <= tac_pkg::GAIN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_gain <= i_cfg_data;
            end
            if (fin) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (cstat.done) begin
                        r_state <= S_FINAL;
                    end
                end
                S_FINAL: begin
                    if (fin) begin
                        r_acc    <= n_acc;
                        r_seeded <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prod <= i_gyro_rate * $signed({1'b0, r_gain});
        end
        if (fin) begin
            r_accel_angle <= tilt;
            r_gyro_tilt   <= {{3{n_acc[tac_pkg::ACC_W-1]}}, n_acc[tac_pkg::ACC_W-1:19]};
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_accel_angle = r_accel_angle;
    assign o_gyro_tilt   = r_gyro_tilt;

    `ASSERT_NEVER(a_idle_cordic_free, i_clk, i_rst_n,
        (r_state == S_IDLE) && cstat.busy, "cordic busy while idle")
    `ASSERT_NEVER(a_done_in_wait, i_clk, i_rst_n,
        cstat.done && (r_state != S_WAIT), "cordic done outside wait")
    `ASSERT_PROP(a_out_from_final, i_clk, i_rst_n,
        $rose(r_out_valid) |-> ($past(r_state) == S_FINAL), "result without update")
    `ASSERT_PROP(a_seed_after_out, i_clk, i_rst_n,
        $rose(r_out_valid) |-> r_seeded, "seed flag not set")

endmodule

// ===== verif/tilt_from_accel_and_gyro_integrator_test.sv =====
// Testbench for tilt_from_accel_and_gyro_integrator: drives IMU samples, predicts the
// CORDIC tilt and the seeded, saturating gyro angle, and checks each result word.
// Depends on the RTL top level and tac_pkg; needs no files or arguments.
module tilt_from_accel_and_gyro_integrator_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     ROT_STEPS     = 16;
    localparam int     SETTLE_CYCLES = 30;
    localparam int     QUIET_LIMIT   = 3000;
    localparam int     HOLD_CYCLES   = 300;
    localparam longint PI_Q24        = 64'sd52707179;
    localparam longint TILT_LIMIT    = 64'sd25736;
    localparam longint ACC_HI        = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACC_LO        = -ACC_HI - 64'sd1;
    localparam longint ATAN_STEP [24] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2
    };

    typedef struct packed {
        logic signed [15:0] tilt;
        logic signed [31:0] gyro;
    } t_angles;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic signed [15:0]            i_accel_y;
    logic signed [15:0]            i_accel_z;
    logic signed [15:0]            i_gyro_rate;
    logic                          o_out_valid;
    logic                          i_out_stall;
    logic signed [15:0]            o_accel_angle;
    logic signed [31:0]            o_gyro_tilt;
    logic                          i_cfg_we;
    logic [tac_pkg::GAIN_W-1:0]    i_cfg_data;

    t_angles                       pending_angles [$];
    logic [tac_pkg::GAIN_W-1:0]    gain_shadow;
    bit                            seeded;
    longint                        gyro_acc;
    bit                            calm;
    int                            hold_req;
    int                            error_count;

    tilt_from_accel_and_gyro_integrator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_accel_y     (i_accel_y),
        .i_accel_z     (i_accel_z),
        .i_gyro_rate   (i_gyro_rate),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_accel_angle (o_accel_angle),
        .o_gyro_tilt   (o_gyro_tilt),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic signed [15:0] tilt_of(input logic signed [15:0] ay,
                                                   input logic signed [15:0] az);
        longint x, y, z, dx, dy, a;
        int     i;
        if (ay == 0 && az == 0) return 16'sd0;
        x = longint'(ay) * 65536;
        y = longint'(az) * 65536;
        z = 0;
        if (x < 0) begin
            z = (y >= 0) ? PI_Q24 : -PI_Q24;
            x = -x;
            y = -y;
        end
        for (i = 0; i < ROT_STEPS && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_STEP[i];
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_STEP[i];
            end
        end
        a = (z + 1024) >>> 11;
        if (a > TILT_LIMIT) a = TILT_LIMIT;
        if (a < -TILT_LIMIT) a = -TILT_LIMIT;
        return 16'(-a);
    endfunction

    // advance the gyro integrator by one sample and give the word it answers with
    function automatic t_angles predict_angles(input logic signed [15:0] ay,
                                               input logic signed [15:0] az,
                                               input logic signed [15:0] rate);
        t_angles r;
        longint  sum, g;
        r.tilt = tilt_of(ay, az);
        if (!seeded) begin
            gyro_acc = longint'(r.tilt) * 524288;
            seeded   = 1'b1;
        end else begin
            sum = gyro_acc + longint'(rate) * longint'(gain_shadow);
            if (sum > ACC_HI) sum = ACC_HI;
            if (sum < ACC_LO) sum = ACC_LO;
            gyro_acc = sum;
        end
        g = gyro_acc >>> 19;
        if (g > 64'sd2147483647) g = 64'sd2147483647;
        if (g < -64'sd2147483648) g = -64'sd2147483648;
        r.gyro = g[31:0];
        return r;
    endfunction

    function automatic logic signed [15:0] random_axis();
        case ($urandom_range(0, 7))
            0: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            1: return 16'($urandom_range(0, 8) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_imu(input logic signed [15:0] ay, input logic signed [15:0] az,
                            input logic signed [15:0] rate);
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_accel_y   = ay;
        i_accel_z   = az;
        i_gyro_rate = rate;
        do @(posedge i_clk); while (o_in_stall);
        pending_angles.push_back(predict_angles(ay, az, rate));
    endtask

    task automatic send_random(input int count);
        repeat (count) send_imu(random_axis(), random_axis(), random_axis());
    endtask

    task automatic wait_all_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_angles.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_rate_gain(input logic [tac_pkg::GAIN_W-1:0] g);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = g;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        gain_shadow = g;
    endtask

    // first word seeds the gyro angle; then axis corners, zero vector, both pi turns
    task automatic test_seed_and_corners();
        send_imu(-1000, 500, 1234);
        send_imu(0, 0, 100);
        send_imu(32767, 0, 32767);
        send_imu(-32768, 0, -32768);
        send_imu(-32768, -1, 0);
        send_imu(0, 32767, -1);
        send_imu(0, -32768, 1);
        send_imu(32767, 32767, 32767);
        send_imu(-32768, -32768, -32768);
        send_imu(32767, -32768, 0);
        send_imu(-32768, 32767, 256);
        send_imu(1, 0, -256);
        send_imu(0, 1, 5);
        send_imu(-1, 0, -5);
        send_imu(0, -1, 32767);
        send_imu(-1, -1, -32768);
        send_imu(1, -1, 0);
        send_imu(0, 0, -32768);
        wait_all_results();
    endtask

    task automatic test_default_gain();
        send_random(120);
        wait_all_results();
    endtask

    task automatic test_gain_settings();
        logic [tac_pkg::GAIN_W-1:0] gains [5];
        gains = '{24'd0, 24'hFFFFFF, 24'd1, 24'($urandom), tac_pkg::GAIN_RESET};
        foreach (gains[k]) begin
            write_rate_gain(gains[k]);
            send_random(40);
            wait_all_results();
        end
    endtask

    // hold the output long enough that the block backs up into its input
    task automatic test_output_hold();
        @(posedge i_clk);
        hold_req = HOLD_CYCLES;
        send_random(30);
        wait_all_results();
    endtask

    // drive the accumulator into both 48-bit bounds at full gain
    task automatic test_accumulator_saturation();
        write_rate_gain(24'hFFFFFF);
        repeat (300)
            send_imu(random_axis(), random_axis(), 16'($urandom_range(30000, 32767)));
        repeat (600)
            send_imu(random_axis(), random_axis(), 16'(-$urandom_range(30000, 32768)));
        wait_all_results();
    endtask

    task automatic test_back_to_back();
        calm = 1'b1;
        write_rate_gain(24'($urandom_range(0, 65535)));
        send_random(80);
        wait_all_results();
    endtask

    initial begin : out_stall_gen
        int burst, slack;
        burst = 0;
        slack = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req > 0) begin
                i_out_stall = 1'b1;
                hold_req--;
            end else if (calm) begin
                i_out_stall = 1'b0;
            end else if (burst > 0) begin
                i_out_stall = 1'b1;
                burst--;
            end else if (slack > 0) begin
                i_out_stall = 1'b0;
                slack--;
            end else begin
                i_out_stall = 1'b0;
                burst = $urandom_range(1, 10);
                slack = $urandom_range(1, 40);
            end
        end
    end

    always @(posedge i_clk) begin : check_angles
        t_angles want;
        if (o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (pending_angles.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual tilt %0d gyro %0d",
                         $time, o_accel_angle, o_gyro_tilt);
                error_count++;
            end else begin
                want = pending_angles.pop_front();
                if (o_accel_angle !== want.tilt) begin
                    $display("%0t: accel_angle expected %0d actual %0d",
                             $time, want.tilt, o_accel_angle);
                    error_count++;
                end
                if (o_gyro_tilt !== want.gyro) begin
                    $display("%0t: gyro_tilt expected %0d actual %0d",
                             $time, want.gyro, o_gyro_tilt);
                    error_count++;
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet = 0;
            else quiet++;
        end
        $display("tilt_from_accel_and_gyro_integrator_test: errors");
        $finish;
    end

    initial begin : run
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_accel_y   = '0;
        i_accel_z   = '0;
        i_gyro_rate = '0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = '0;
        gain_shadow = tac_pkg::GAIN_RESET;
        seeded      = 1'b0;
        gyro_acc    = 0;
        calm        = 1'b0;
        hold_req    = 0;
        error_count = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_seed_and_corners();
        test_default_gain();
        test_gain_settings();
        test_output_hold();
        test_accumulator_saturation();
        test_back_to_back();
        if (error_count == 0) begin
            $display("tilt_from_accel_and_gyro_integrator_test: clean");
        end else begin
            $display("tilt_from_accel_and_gyro_integrator_test: errors");
        end
        $finish;
    end
endmodule
